### sv/ucd_pkg.sv
`timescale 1ns / 1ps
// Types, codes and control store for the undirected cycle detector.
package ucd_pkg;

    localparam int MAX_VERTICES = 128;
    localparam int VTX_W        = $clog2(MAX_VERTICES);
    localparam int CNT_W        = VTX_W + 1;

    typedef logic [VTX_W-1:0]        vtx_t;
    typedef logic [CNT_W-1:0]        cnt_t;
    typedef logic [MAX_VERTICES-1:0] row_t;

    // Item function codes
    localparam logic [1:0] FUNC_ADD   = 2'd0;
    localparam logic [1:0] FUNC_CHECK = 2'd1;
    localparam logic [1:0] FUNC_CLEAR = 2'd2;

    typedef struct packed {
        logic [1:0] func;
        vtx_t       edge_u;
        vtx_t       edge_v;
    } in_item_t;

    typedef struct packed {
        logic has_cycle;
        logic bad_edge_seen;
    } out_item_t;

    // One search frame: vertex, its parent, next neighbour to scan
    typedef struct packed {
        vtx_t vertex;
        vtx_t parent;
        cnt_t next_w;
    } frame_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_IDLE,
        OP_ADD_CHK,
        OP_WR_U,
        OP_RD_V,
        OP_WR_V,
        OP_CHK_INIT,
        OP_START,
        OP_LOAD_ROW,
        OP_SCAN,
        OP_SET_CYCLE,
        OP_INC_W,
        OP_PUSH,
        OP_POP,
        OP_UNSTACK,
        OP_INC_I,
        OP_REPORT
    } op_t;

    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_DISPATCH,
        C_BAD,
        C_I_GT_N,
        C_I_VISITED,
        C_SCAN_MISS,
        C_W_GT_N,
        C_W_UNVISITED,
        C_W_IS_PARENT,
        C_DEPTH_ONE,
        C_OUT_FREE
    } cond_t;

    typedef logic [4:0] step_t;

    localparam step_t S_IDLE   = 5'd0;
    localparam step_t S_ADD0   = 5'd1;
    localparam step_t S_ADD1   = 5'd2;
    localparam step_t S_ADD2   = 5'd3;
    localparam step_t S_ADD3   = 5'd4;
    localparam step_t S_CHK0   = 5'd5;
    localparam step_t S_ROOT   = 5'd6;
    localparam step_t S_ROOTV  = 5'd7;
    localparam step_t S_START  = 5'd8;
    localparam step_t S_LOAD   = 5'd9;
    localparam step_t S_SCAN   = 5'd10;
    localparam step_t S_TEND   = 5'd11;
    localparam step_t S_TNEW   = 5'd12;
    localparam step_t S_TPAR   = 5'd13;
    localparam step_t S_FOUND  = 5'd14;
    localparam step_t S_SKIP   = 5'd15;
    localparam step_t S_PUSH   = 5'd16;
    localparam step_t S_POP    = 5'd17;
    localparam step_t S_POP1   = 5'd18;
    localparam step_t S_RNEXT  = 5'd19;
    localparam step_t S_REPORT = 5'd20;
    localparam step_t S_RWAIT  = 5'd21;

    typedef struct packed {
        op_t   op;
        cond_t cond;
        step_t target;
    } uword_t;

    // Control store: jump to target when cond holds, else fall through
    function automatic uword_t ucode_rom(step_t s);
        uword_t w;
        unique case (s)
            S_IDLE:   w = '{OP_IDLE,      C_DISPATCH,    S_IDLE};
            S_ADD0:   w = '{OP_ADD_CHK,   C_BAD,         S_IDLE};
            S_ADD1:   w = '{OP_WR_U,      C_NEVER,       S_IDLE};
            S_ADD2:   w = '{OP_RD_V,      C_NEVER,       S_IDLE};
            S_ADD3:   w = '{OP_WR_V,      C_ALWAYS,      S_IDLE};
            S_CHK0:   w = '{OP_CHK_INIT,  C_NEVER,       S_IDLE};
            S_ROOT:   w = '{OP_NOP,       C_I_GT_N,      S_REPORT};
            S_ROOTV:  w = '{OP_NOP,       C_I_VISITED,   S_RNEXT};
            S_START:  w = '{OP_START,     C_NEVER,       S_IDLE};
            S_LOAD:   w = '{OP_LOAD_ROW,  C_NEVER,       S_IDLE};
            S_SCAN:   w = '{OP_SCAN,      C_SCAN_MISS,   S_SCAN};
            S_TEND:   w = '{OP_NOP,       C_W_GT_N,      S_POP};
            S_TNEW:   w = '{OP_NOP,       C_W_UNVISITED, S_PUSH};
            S_TPAR:   w = '{OP_NOP,       C_W_IS_PARENT, S_SKIP};
            S_FOUND:  w = '{OP_SET_CYCLE, C_ALWAYS,      S_REPORT};
            S_SKIP:   w = '{OP_INC_W,     C_ALWAYS,      S_SCAN};
            S_PUSH:   w = '{OP_PUSH,      C_ALWAYS,      S_LOAD};
            S_POP:    w = '{OP_POP,       C_DEPTH_ONE,   S_RNEXT};
            S_POP1:   w = '{OP_UNSTACK,   C_ALWAYS,      S_LOAD};
            S_RNEXT:  w = '{OP_INC_I,     C_ALWAYS,      S_ROOT};
            S_REPORT: w = '{OP_REPORT,    C_OUT_FREE,    S_IDLE};
            S_RWAIT:  w = '{OP_NOP,       C_ALWAYS,      S_REPORT};
            default:  w = '{OP_NOP,       C_ALWAYS,      S_IDLE};
        endcase
        return w;
    endfunction

    // Entry step for an accepted item
    function automatic step_t dispatch(logic [1:0] func);
        step_t s;
        unique case (func)
            FUNC_ADD:   s = S_ADD0;
            FUNC_CHECK: s = S_CHK0;
            default:    s = S_IDLE;
        endcase
        return s;
    endfunction

endpackage

### sv/undirected_cycle_detector_core.sv
`timescale 1ns / 1ps
// Undirected cycle detector: microcoded depth-first search over an adjacency bit matrix.
// Add: read-modify-write of row u, then of row v, in the adjacency RAM; a bad edge sets
//   the sticky flag and writes nothing. Clear and unused codes: done in the idle step.
//   Check: depth-first search, adjacency bits scanned one per cycle; a cycle found ends
//   the search early. Only Check gives a result, in m_data.
// One item at a time; the result register lets the next item in while a result waits.
// Reset (aresetn low, synchronous): graph empty through row valid bits, flag clear,
//   vertex limit (vcount_reg) = 1; no clearing pass.
module undirected_cycle_detector_core (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  ucd_pkg::in_item_t   s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output ucd_pkg::out_item_t  m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  ucd_pkg::vtx_t       cfg_data
);

    // ---------------------------------------------------------------
    // Sequencer state
    // ---------------------------------------------------------------
    ucd_pkg::step_t  step_reg, step_next;
    ucd_pkg::uword_t uw;

    // ---------------------------------------------------------------
    // Datapath registers
    // ---------------------------------------------------------------
    ucd_pkg::vtx_t      vcount_reg, vcount_next;    // vertex limit
    ucd_pkg::vtx_t      in_u_reg, in_u_next;
    ucd_pkg::vtx_t      in_v_reg, in_v_next;
    logic               bad_reg, bad_next;          // sticky bad-edge flag
    ucd_pkg::row_t      row_valid_reg, row_valid_next;
    ucd_pkg::row_t      row_reg, row_next;          // row of the top-of-stack vertex
    ucd_pkg::row_t      visited_reg, visited_next;
    ucd_pkg::vtx_t      top_v_reg, top_v_next;      // top frame lives in registers
    ucd_pkg::vtx_t      top_p_reg, top_p_next;
    ucd_pkg::cnt_t      w_reg, w_next;              // scan pointer of top frame
    ucd_pkg::cnt_t      depth_reg, depth_next;      // frames including the top one
    ucd_pkg::cnt_t      i_reg, i_next;              // root candidate
    logic               cyc_reg, cyc_next;
    logic               m_valid_reg, m_valid_next;
    ucd_pkg::out_item_t m_data_reg, m_data_next;

    // ---------------------------------------------------------------
    // Memories: adjacency rows and frames below the top
    // ---------------------------------------------------------------
    ucd_pkg::row_t   adj_mem [ucd_pkg::MAX_VERTICES];
    ucd_pkg::frame_t stk_mem [ucd_pkg::MAX_VERTICES];

    ucd_pkg::row_t   adj_rd_reg;
    logic            adj_rvld_reg;  // row was written since the last clear
    ucd_pkg::frame_t stk_rd_reg;

    logic            adj_re, adj_we, stk_re, stk_we;
    ucd_pkg::vtx_t   adj_raddr, adj_waddr, stk_raddr, stk_waddr;
    ucd_pkg::row_t   adj_wdata;
    ucd_pkg::frame_t stk_wdata;

    // ---------------------------------------------------------------
    // Conditions
    // ---------------------------------------------------------------
    ucd_pkg::cnt_t n_ext, w_inc, depth_m1, depth_m2;
    ucd_pkg::vtx_t w_idx, i_idx;
    ucd_pkg::row_t rd_eff;
    logic          bad_edge, i_gt_n, w_gt_n, scan_miss, out_free, cond_true;

    assign n_ext    = {1'b0, vcount_reg};
    assign w_inc    = w_reg + ucd_pkg::cnt_t'(1);
    assign depth_m1 = depth_reg - ucd_pkg::cnt_t'(1);
    assign depth_m2 = depth_reg - ucd_pkg::cnt_t'(2);
    assign w_idx    = w_reg[ucd_pkg::VTX_W-1:0];
    assign i_idx    = i_reg[ucd_pkg::VTX_W-1:0];

    // Rows not written since the last clear read as empty
    assign rd_eff   = adj_rvld_reg ? adj_rd_reg : '0;

    // Vertex zero or above the limit discards the edge
    assign bad_edge = (in_u_reg == '0) || (in_v_reg == '0) ||
                      (in_u_reg > vcount_reg) || (in_v_reg > vcount_reg);

    assign i_gt_n    = i_reg > n_ext;
    assign w_gt_n    = w_reg > n_ext;
    assign scan_miss = !w_gt_n && !row_reg[w_idx];
    assign out_free  = !m_valid_reg || m_ready;

    assign uw = ucd_pkg::ucode_rom(step_reg);

    always_comb begin
        unique case (uw.cond)
            ucd_pkg::C_NEVER:       cond_true = 1'b0;
            ucd_pkg::C_ALWAYS:      cond_true = 1'b1;
            ucd_pkg::C_DISPATCH:    cond_true = 1'b1;
            ucd_pkg::C_BAD:         cond_true = bad_edge;
            ucd_pkg::C_I_GT_N:      cond_true = i_gt_n;
            ucd_pkg::C_I_VISITED:   cond_true = visited_reg[i_idx];
            ucd_pkg::C_SCAN_MISS:   cond_true = scan_miss;
            ucd_pkg::C_W_GT_N:      cond_true = w_gt_n;
            ucd_pkg::C_W_UNVISITED: cond_true = !visited_reg[w_idx];
            ucd_pkg::C_W_IS_PARENT: cond_true = (w_idx == top_p_reg);
            ucd_pkg::C_DEPTH_ONE:   cond_true = (depth_reg == ucd_pkg::cnt_t'(1));
            ucd_pkg::C_OUT_FREE:    cond_true = out_free;
            default:                cond_true = 1'b0;
        endcase
    end

    // Step counter: dispatch on the item, conditional jump or fall through
    always_comb begin
        if (uw.cond == ucd_pkg::C_DISPATCH) begin
            step_next = s_valid ? ucd_pkg::dispatch(s_data.func) : ucd_pkg::S_IDLE;
        end else if (cond_true) begin
            step_next = uw.target;
        end else begin
            step_next = step_reg + ucd_pkg::step_t'(1);
        end
    end

    assign s_ready   = (uw.op == ucd_pkg::OP_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = m_valid_reg;
    assign m_data    = m_data_reg;

    // ---------------------------------------------------------------
    // Datapath driven by the control word
    // ---------------------------------------------------------------
    always_comb begin
        vcount_next    = vcount_reg;
        in_u_next      = in_u_reg;
        in_v_next      = in_v_reg;
        bad_next       = bad_reg;
        row_valid_next = row_valid_reg;
        row_next       = row_reg;
        visited_next   = visited_reg;
        top_v_next     = top_v_reg;
        top_p_next     = top_p_reg;
        w_next         = w_reg;
        depth_next     = depth_reg;
        i_next         = i_reg;
        cyc_next       = cyc_reg;
        m_valid_next   = m_valid_reg && !m_ready;
        m_data_next    = m_data_reg;
        adj_re         = 1'b0;
        adj_raddr      = in_u_reg;
        adj_we         = 1'b0;
        adj_waddr      = in_u_reg;
        adj_wdata      = rd_eff;
        stk_re         = 1'b0;
        stk_raddr      = depth_m2[ucd_pkg::VTX_W-1:0];
        stk_we         = 1'b0;
        stk_waddr      = depth_m1[ucd_pkg::VTX_W-1:0];
        stk_wdata      = '{top_v_reg, top_p_reg, w_inc};

        if (cfg_valid) begin
            vcount_next = cfg_data;
        end

        case (uw.op)
            ucd_pkg::OP_IDLE: begin
                if (s_valid) begin
                    in_u_next = s_data.edge_u;
                    in_v_next = s_data.edge_v;
                    if (s_data.func == ucd_pkg::FUNC_CLEAR) begin
                        row_valid_next = '0;
                        bad_next       = 1'b0;
                    end
                end
            end
            ucd_pkg::OP_ADD_CHK: begin
                if (bad_edge) begin
                    bad_next = 1'b1;
                end else begin
                    adj_re = 1'b1;
                end
            end
            ucd_pkg::OP_WR_U: begin
                adj_we                   = 1'b1;
                adj_wdata                = rd_eff | (ucd_pkg::row_t'(1) << in_v_reg);
                row_valid_next[in_u_reg] = 1'b1;
            end
            ucd_pkg::OP_RD_V: begin
                adj_re    = 1'b1;
                adj_raddr = in_v_reg;
            end
            ucd_pkg::OP_WR_V: begin
                adj_we                   = 1'b1;
                adj_waddr                = in_v_reg;
                adj_wdata                = rd_eff | (ucd_pkg::row_t'(1) << in_u_reg);
                row_valid_next[in_v_reg] = 1'b1;
            end
            ucd_pkg::OP_CHK_INIT: begin
                visited_next = '0;
                i_next       = ucd_pkg::cnt_t'(1);
                cyc_next     = 1'b0;
            end
            ucd_pkg::OP_START: begin
                depth_next          = ucd_pkg::cnt_t'(1);
                top_v_next          = i_idx;
                top_p_next          = '0;   // a root has no parent
                w_next              = ucd_pkg::cnt_t'(1);
                visited_next[i_idx] = 1'b1;
                adj_re              = 1'b1;
                adj_raddr           = i_idx;
            end
            ucd_pkg::OP_LOAD_ROW: begin
                row_next = rd_eff;
            end
            ucd_pkg::OP_SCAN: begin
                if (scan_miss) begin
                    w_next = w_inc;
                end
            end
            ucd_pkg::OP_SET_CYCLE: begin
                cyc_next = 1'b1;
            end
            ucd_pkg::OP_INC_W: begin
                w_next = w_inc;
            end
            ucd_pkg::OP_PUSH: begin
                // spill the top frame, resume it past w later
                stk_we              = 1'b1;
                top_v_next          = w_idx;
                top_p_next          = top_v_reg;
                w_next              = ucd_pkg::cnt_t'(1);
                depth_next          = depth_reg + ucd_pkg::cnt_t'(1);
                visited_next[w_idx] = 1'b1;
                adj_re              = 1'b1;
                adj_raddr           = w_idx;
            end
            ucd_pkg::OP_POP: begin
                depth_next = depth_m1;
                stk_re     = (depth_reg != ucd_pkg::cnt_t'(1));
            end
            ucd_pkg::OP_UNSTACK: begin
                top_v_next = stk_rd_reg.vertex;
                top_p_next = stk_rd_reg.parent;
                w_next     = stk_rd_reg.next_w;
                adj_re     = 1'b1;
                adj_raddr  = stk_rd_reg.vertex;
            end
            ucd_pkg::OP_INC_I: begin
                i_next = i_reg + ucd_pkg::cnt_t'(1);
            end
            ucd_pkg::OP_REPORT: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_data_next  = '{cyc_reg, bad_reg};
                end
            end
            default: begin
            end
        endcase
    end

    // ---------------------------------------------------------------
    // Registers
    // ---------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg      <= ucd_pkg::S_IDLE;
            vcount_reg    <= ucd_pkg::vtx_t'(1);
            bad_reg       <= 1'b0;
            row_valid_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            step_reg      <= step_next;
            vcount_reg    <= vcount_next;
            bad_reg       <= bad_next;
            row_valid_reg <= row_valid_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        in_u_reg    <= in_u_next;
        in_v_reg    <= in_v_next;
        row_reg     <= row_next;
        visited_reg <= visited_next;
        top_v_reg   <= top_v_next;
        top_p_reg   <= top_p_next;
        w_reg       <= w_next;
        depth_reg   <= depth_next;
        i_reg       <= i_next;
        cyc_reg     <= cyc_next;
        m_data_reg  <= m_data_next;
    end

    // Adjacency RAM: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (adj_we) begin
            adj_mem[adj_waddr] <= adj_wdata;
        end
        if (adj_re) begin
            adj_rd_reg   <= adj_mem[adj_raddr];
            adj_rvld_reg <= row_valid_reg[adj_raddr];
        end
    end

    // Frame stack RAM
    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[stk_waddr] <= stk_wdata;
        end
        if (stk_re) begin
            stk_rd_reg <= stk_mem[stk_raddr];
        end
    end

endmodule
